// ===== rtl/core/etho_pkg.sv =====
// Shared constants, register codes and structs for the edge trigger with holdoff.
// No dependencies; every other file of the block depends on this package.
package etho_pkg;

   localparam int SAMPLES_PER_CHUNK = 64;
   localparam int NUM_CHANNELS      = 8;

   localparam int POS_W       = 6;
   localparam int CHUNK_W     = 32;
   localparam int SAMPLE_W    = 16;
   localparam int CH_W        = 3;
   localparam int COUNT_W     = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 3;

   // Edge selection codes
   localparam logic [MODE_W-1:0] EDGE_RISING  = 2'd0;
   localparam logic [MODE_W-1:0] EDGE_FALLING = 2'd1;
   localparam logic [MODE_W-1:0] EDGE_EITHER  = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [CSR_IDX_W-1:0] REG_TRIG_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_MODE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TRIG_LEVEL     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_CHANNEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PRE_CHUNKS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POST_CHUNKS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HOLDOFF_CHUNKS = 3'd6;

   typedef struct packed {
      logic                trig_enable;
      logic [MODE_W-1:0]   edge_mode;
      logic [SAMPLE_W-1:0] trig_level;
      logic [CH_W-1:0]     source_channel;
      logic [COUNT_W-1:0]  pre_chunks;
      logic [COUNT_W-1:0]  post_chunks;
      logic [COUNT_W-1:0]  holdoff_chunks;
   } cfg_type;

   typedef struct packed {
      logic               fired;
      logic               searching;
      logic               holding_off;
      logic [CHUNK_W-1:0] trig_chunk;
      logic [POS_W-1:0]   trig_offset;
   } step_type;

endpackage

// ===== rtl/core/etho_if.sv =====
// Valid/ready channel interfaces for requests and results of the edge trigger.
// Depends on etho_pkg for the field widths.
interface etho_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [etho_pkg::SAMPLE_W-1:0] sample;
   logic [etho_pkg::CH_W-1:0]            channel;
   logic                                 chunk_end;

   modport source (output valid, sample, channel, chunk_end, input ready);
   modport sink   (input valid, sample, channel, chunk_end, output ready);
endinterface

interface etho_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             fired;
   logic                             searching;
   logic                             holding_off;
   logic [etho_pkg::CHUNK_W-1:0]     trig_chunk;
   logic [etho_pkg::POS_W-1:0]       trig_offset;
   logic [etho_pkg::CHUNK_W-1:0]     window_first;
   logic [etho_pkg::CHUNK_W-1:0]     window_last;

   modport source (output valid, fired, searching, holding_off, trig_chunk, trig_offset,
                   window_first, window_last, input ready);
   modport sink   (input valid, fired, searching, holding_off, trig_chunk, trig_offset,
                   window_first, window_last, output ready);
endinterface

// ===== rtl/core/etho_csr.sv =====
// APB-style configuration registers of the edge trigger.
// Depends on etho_pkg.
module etho_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [etho_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [etho_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [etho_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output etho_pkg::cfg_type                 cfg
);
   import etho_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [CSR_IDX_W-1:0]  idx;
   logic                  wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_TRIG_ENABLE:    cfg_in.trig_enable    = csr_pwdata[0];
            REG_EDGE_MODE:      cfg_in.edge_mode      = csr_pwdata[MODE_W-1:0];
            REG_TRIG_LEVEL:     cfg_in.trig_level     = csr_pwdata[SAMPLE_W-1:0];
            REG_SOURCE_CHANNEL: cfg_in.source_channel = csr_pwdata[CH_W-1:0];
            REG_PRE_CHUNKS:     cfg_in.pre_chunks     = csr_pwdata[COUNT_W-1:0];
            REG_POST_CHUNKS:    cfg_in.post_chunks    = csr_pwdata[COUNT_W-1:0];
            REG_HOLDOFF_CHUNKS: cfg_in.holdoff_chunks = csr_pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (idx)
         REG_TRIG_ENABLE:    csr_prdata[0]            = cfg_ff.trig_enable;
         REG_EDGE_MODE:      csr_prdata[MODE_W-1:0]   = cfg_ff.edge_mode;
         REG_TRIG_LEVEL:     csr_prdata               = CSR_DATA_W'($signed(cfg_ff.trig_level));
         REG_SOURCE_CHANNEL: csr_prdata[CH_W-1:0]     = cfg_ff.source_channel;
         REG_PRE_CHUNKS:     csr_prdata[COUNT_W-1:0]  = cfg_ff.pre_chunks;
         REG_POST_CHUNKS:    csr_prdata[COUNT_W-1:0]  = cfg_ff.post_chunks;
         REG_HOLDOFF_CHUNKS: csr_prdata[COUNT_W-1:0]  = cfg_ff.holdoff_chunks;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trig_enable    <= 1'b0;
         cfg_ff.edge_mode      <= EDGE_RISING;
         cfg_ff.trig_level     <= 16'd3277;
         cfg_ff.source_channel <= '0;
         cfg_ff.pre_chunks     <= 8'd4;
         cfg_ff.post_chunks    <= 8'd17;
         cfg_ff.holdoff_chunks <= 8'd40;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/etho_trig.sv =====
// Trigger state: chunk counter, sample position, arm/fire/holdoff flags.
// Depends on etho_pkg; produces one step result per accepted request.
module etho_trig (
   input  logic                                 clock,
   input  logic                                 reset,
   input  etho_pkg::cfg_type                    cfg,
   input  logic                                 req_take,
   input  logic signed [etho_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [etho_pkg::CH_W-1:0]            req_channel,
   input  logic                                 req_chunk_end,
   output etho_pkg::step_type                   step
);
   import etho_pkg::*;

   logic [CHUNK_W-1:0] chunk_count_ff, chunk_count_in;
   logic [POS_W-1:0]   sample_pos_ff, sample_pos_in;
   logic               armed_ff, armed_in;
   logic               was_over_ff, was_over_in;
   logic               triggered_ff, triggered_in;
   logic [CHUNK_W-1:0] trig_chunk_ff, trig_chunk_in;
   logic [POS_W-1:0]   trig_offset_ff, trig_offset_in;

   logic                       is_src;
   logic                       hunt;
   logic                       over;
   logic                       under;
   logic                       fire;
   logic signed [SAMPLE_W-1:0] level;
   logic [CHUNK_W-1:0]         since_trig;

   assign level = $signed(cfg.trig_level);
   assign over  = req_sample > level;
   assign under = req_sample < level;

   always_comb begin
      is_src = (req_channel == cfg.source_channel) && (int'(req_channel) < NUM_CHANNELS);
      hunt   = cfg.trig_enable && !triggered_ff && is_src;

      armed_in       = armed_ff;
      was_over_in    = was_over_ff;
      triggered_in   = triggered_ff;
      trig_chunk_in  = trig_chunk_ff;
      trig_offset_in = trig_offset_ff;
      fire           = 1'b0;

      if (hunt) begin
         // arm on the far side of the level
         if (!armed_ff) begin
            case (cfg.edge_mode)
               EDGE_RISING:  if (under) armed_in = 1'b1;
               EDGE_FALLING: if (over) armed_in = 1'b1;
               EDGE_EITHER: begin
                  armed_in    = 1'b1;
                  was_over_in = over;
               end
               default: ;
            endcase
         end
         // fire on a strict crossing
         if (armed_in) begin
            case (cfg.edge_mode)
               EDGE_RISING:  fire = over;
               EDGE_FALLING: fire = under;
               EDGE_EITHER:  fire = was_over_in ? under : over;
               default:      fire = 1'b0;
            endcase
         end
         if (fire) begin
            triggered_in   = 1'b1;
            trig_chunk_in  = chunk_count_ff;
            trig_offset_in = sample_pos_ff;
         end
      end

      sample_pos_in  = sample_pos_ff;
      if (is_src && (int'(sample_pos_ff) < SAMPLES_PER_CHUNK - 1)) begin
         sample_pos_in = sample_pos_ff + POS_W'(1);
      end

      chunk_count_in = chunk_count_ff;
      since_trig     = '0;
      if (req_chunk_end) begin
         chunk_count_in = chunk_count_ff + CHUNK_W'(1);
         sample_pos_in  = '0;
         since_trig     = chunk_count_in - trig_chunk_in;
         // release holdoff once the count is past trigger plus dead time
         if (cfg.trig_enable && triggered_in &&
             (since_trig > CHUNK_W'(cfg.holdoff_chunks))) begin
            triggered_in = 1'b0;
            armed_in     = 1'b0;
         end
      end

      step.fired       = fire;
      step.searching   = cfg.trig_enable && !triggered_in;
      step.holding_off = cfg.trig_enable && triggered_in;
      step.trig_chunk  = trig_chunk_in;
      step.trig_offset = trig_offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_count_ff <= '0;
         sample_pos_ff  <= '0;
         armed_ff       <= 1'b0;
         was_over_ff    <= 1'b0;
         triggered_ff   <= 1'b0;
         trig_chunk_ff  <= '0;
         trig_offset_ff <= '0;
      end else if (req_take) begin
         chunk_count_ff <= chunk_count_in;
         sample_pos_ff  <= sample_pos_in;
         armed_ff       <= armed_in;
         was_over_ff    <= was_over_in;
         triggered_ff   <= triggered_in;
         trig_chunk_ff  <= trig_chunk_in;
         trig_offset_ff <= trig_offset_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      int'(sample_pos_ff) <= SAMPLES_PER_CHUNK - 1)
      else $error("sample position past chunk length");

   a_fire_records: assert property (@(posedge clock) disable iff (reset)
      req_take && fire |=> trig_chunk_ff == $past(chunk_count_ff))
      else $error("trigger chunk not recorded on fire");

   a_fire_only_hunting: assert property (@(posedge clock) disable iff (reset)
      fire |-> cfg.trig_enable && !triggered_ff && is_src)
      else $error("fire outside edge search");

endmodule

// ===== rtl/core/etho_rsp_stage.sv =====
// Result register: display window arithmetic and output holding stage.
// Depends on etho_pkg and etho_rsp_if.
module etho_rsp_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  etho_pkg::step_type            step,
   input  logic [etho_pkg::COUNT_W-1:0]  pre_chunks,
   input  logic [etho_pkg::COUNT_W-1:0]  post_chunks,
   output logic                          open,
   etho_rsp_if.source                    rsp_bus
);
   import etho_pkg::*;

   logic               valid_ff;
   step_type           step_ff;
   logic [CHUNK_W-1:0] first_ff, first_in;
   logic [CHUNK_W-1:0] last_ff, last_in;
   logic [CHUNK_W:0]   last_sum;

   always_comb begin
      if (step.trig_chunk >= CHUNK_W'(pre_chunks)) begin
         first_in = step.trig_chunk - CHUNK_W'(pre_chunks);
      end else begin
         first_in = '0;
      end
      last_sum = {1'b0, step.trig_chunk} + (CHUNK_W + 1)'(post_chunks);
      last_in  = last_sum[CHUNK_W] ? '1 : last_sum[CHUNK_W-1:0];
   end

   // take a new request whenever the held result leaves or none is held
   assign open = !valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         step_ff  <= step;
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_bus.valid        = valid_ff;
   assign rsp_bus.fired        = step_ff.fired;
   assign rsp_bus.searching    = step_ff.searching;
   assign rsp_bus.holding_off  = step_ff.holding_off;
   assign rsp_bus.trig_chunk   = step_ff.trig_chunk;
   assign rsp_bus.trig_offset  = step_ff.trig_offset;
   assign rsp_bus.window_first = first_ff;
   assign rsp_bus.window_last  = last_ff;

   a_modes_exclusive: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(step_ff.searching && step_ff.holding_off))
      else $error("searching and holding off together");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> first_ff <= step_ff.trig_chunk && last_ff >= step_ff.trig_chunk)
      else $error("display window does not enclose trigger chunk");

endmodule

// ===== rtl/core/edge_trigger_with_holdoff.sv =====
// Edge trigger with holdoff: top level joining registers, trigger state and result stage.
// An accepted request's result is loaded into the result register as it is accepted.
// Throughput: one request per cycle; a held result stalls requests until it is taken.
// Reset (synchronous, active high) clears chunk count, position, trigger flags and the
// recorded trigger, empties the result register and loads the register defaults.
module edge_trigger_with_holdoff (
   input  logic                              clock,
   input  logic                              reset,
   etho_req_if.sink                          req_bus,
   etho_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [etho_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [etho_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [etho_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import etho_pkg::*;

   cfg_type  cfg;
   step_type step;
   logic     stage_open;
   logic     req_take;

   // Configuration: trigger enable, edge, level, source channel, window sizes and holdoff.
   etho_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Accept a request whenever the result stage can hold its result: either it is
   // empty or its current result leaves in this same cycle.
   assign req_bus.ready = stage_open;
   assign req_take      = req_bus.valid && stage_open;

   // Trigger state advances once per accepted request; the step result reflects the
   // state after that request, as the window and flags must.
   etho_trig u_trig (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_take      (req_take),
      .req_sample    (req_bus.sample),
      .req_channel   (req_bus.channel),
      .req_chunk_end (req_bus.chunk_end),
      .step          (step)
   );

   // Window first/last are derived from the recorded trigger chunk, then held in the
   // result register until the consumer takes them.
   etho_rsp_stage u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (req_take),
      .step        (step),
      .pre_chunks  (cfg.pre_chunks),
      .post_chunks (cfg.post_chunks),
      .open        (stage_open),
      .rsp_bus     (rsp_bus)
   );

endmodule
